// ===== rtl/core/assert_macros.svh =====
// shared assertion macros, clocked on clk with rst_n low holding them off
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JFW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jfw assertion failed");

// next-cycle implication
`define JFW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jfw assertion failed");

`endif

// ===== rtl/core/jfw_pkg.sv =====
package jfw_pkg;

    localparam int CHAR_W      = 8;
    localparam int LIMIT_W     = 9;
    localparam int BAND_W      = 8;
    localparam int PERIOD_W    = 10;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int AXIS_W      = 14;
    localparam int DRIVE_W     = 15;
    localparam int NUM_STAGES  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_BAND   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD  = 2'd2;

    localparam logic [LIMIT_W-1:0]  SPEED_LIMIT_RESET = 9'd499;
    localparam logic [BAND_W-1:0]   DEAD_BAND_RESET   = 8'd20;
    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET  = 10'd500;

    localparam int DIGIT_BASE    = 48;
    localparam int AXIS_IN_LOW   = 10;
    localparam int AXIS_OUT_SPAN = 127;
    // tens*10 + ones - 11*'0' - low end of the axis range
    localparam int AXIS_BIAS     = DIGIT_BASE * 11 + AXIS_IN_LOW;

    // axis scale 254/80 = 127/40, the /40 done as >>3 then /5
    localparam int                AXIS_PRE_SHIFT = 3;
    localparam logic [15:0]       DIV5_RECIP     = 16'hCCCD;
    localparam int                DIV5_SHIFT     = 18;
    // drive scale 2*lim/254 = lim/127
    localparam logic [23:0]       DIV127_RECIP   = 24'd8454661;
    localparam int                DIV127_SHIFT   = 30;

    typedef struct packed {
        logic first;
        logic mid;
        logic last;
    } jfw_stage_en_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  speed_limit;
        logic [BAND_W-1:0]   dead_band;
        logic [PERIOD_W-1:0] pwm_period;
    } jfw_cfg_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] direct_cmp;
        logic                direct_dir;
        logic [PERIOD_W-1:0] inv_cmp;
        logic                inv_dir;
    } jfw_wheel_pair_t;

endpackage

// ===== rtl/core/jfw_channels.sv =====
interface jfw_in_if;
    logic                      valid;
    logic                      ready;
    logic [jfw_pkg::CHAR_W-1:0] x_tens_char;
    logic [jfw_pkg::CHAR_W-1:0] x_ones_char;
    logic [jfw_pkg::CHAR_W-1:0] y_tens_char;
    logic [jfw_pkg::CHAR_W-1:0] y_ones_char;

    modport source (
        output valid, x_tens_char, x_ones_char, y_tens_char, y_ones_char,
        input  ready
    );
    modport sink (
        input  valid, x_tens_char, x_ones_char, y_tens_char, y_ones_char,
        output ready
    );
endinterface

interface jfw_out_if;
    logic                        valid;
    logic                        ready;
    logic [jfw_pkg::PERIOD_W-1:0] front_left_compare;
    logic                        front_left_dir;
    logic [jfw_pkg::PERIOD_W-1:0] front_right_compare;
    logic                        front_right_dir;
    logic [jfw_pkg::PERIOD_W-1:0] rear_right_compare;
    logic                        rear_right_dir;
    logic [jfw_pkg::PERIOD_W-1:0] rear_left_compare;
    logic                        rear_left_dir;

    modport source (
        output valid, front_left_compare, front_left_dir, front_right_compare,
               front_right_dir, rear_right_compare, rear_right_dir,
               rear_left_compare, rear_left_dir,
        input  ready
    );
    modport sink (
        input  valid, front_left_compare, front_left_dir, front_right_compare,
               front_right_dir, rear_right_compare, rear_right_dir,
               rear_left_compare, rear_left_dir,
        output ready
    );
endinterface

// ===== rtl/core/jfw_axis.sv =====
module jfw_axis (
    input  logic                               clk,
    input  jfw_pkg::jfw_stage_en_t             en,
    input  logic [jfw_pkg::CHAR_W-1:0]         tens_char,
    input  logic [jfw_pkg::CHAR_W-1:0]         ones_char,
    output logic signed [jfw_pkg::AXIS_W-1:0]  axis
);

    logic [jfw_pkg::CHAR_W-1:0]        tens_reg;
    logic [jfw_pkg::CHAR_W-1:0]        ones_reg;
    logic [15:0]                       scaled_reg;
    logic [15:0]                       scaled_next;
    logic                              neg_reg;
    logic                              neg_next;
    logic signed [jfw_pkg::AXIS_W-1:0] axis_reg;
    logic signed [jfw_pkg::AXIS_W-1:0] axis_next;

    logic [11:0]        raw;
    logic signed [12:0] offset;
    logic [12:0]        offset_flip;
    logic [11:0]        mag;
    logic [18:0]        times127;
    logic [31:0]        recip_prod;
    logic [12:0]        quot;
    logic signed [jfw_pkg::AXIS_W-1:0] quot_s;
    logic signed [jfw_pkg::AXIS_W-1:0] span_s;

    // digits to magnitude of (a - low) * 127 / 8
    always_comb
    begin
        raw         = 12'(tens_reg) * 12'd10 + 12'(ones_reg);
        offset      = $signed({1'b0, raw}) - $signed(13'(jfw_pkg::AXIS_BIAS));
        offset_flip = 13'(-offset);
        neg_next    = offset[12];
        mag         = offset[12] ? offset_flip[11:0] : offset[11:0];
        times127    = {mag, 7'b0} - {7'b0, mag};
        scaled_next = times127[18:jfw_pkg::AXIS_PRE_SHIFT];
    end

    // divide by 5, restore sign, shift down by the span
    always_comb
    begin
        recip_prod = 32'(scaled_reg) * 32'(jfw_pkg::DIV5_RECIP);
        quot       = recip_prod[jfw_pkg::DIV5_SHIFT +: 13];
        quot_s     = $signed({1'b0, quot});
        span_s     = $signed(14'(jfw_pkg::AXIS_OUT_SPAN));
        axis_next  = neg_reg ? (-quot_s - span_s) : (quot_s - span_s);
    end

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            tens_reg <= tens_char;
            ones_reg <= ones_char;
        end
        if (en.mid)
        begin
            scaled_reg <= scaled_next;
            neg_reg    <= neg_next;
        end
        if (en.last)
        begin
            axis_reg <= axis_next;
        end
    end

    assign axis = axis_reg;

endmodule

// ===== rtl/core/jfw_drive.sv =====
module jfw_drive (
    input  logic                               clk,
    input  jfw_pkg::jfw_stage_en_t             en,
    input  jfw_pkg::jfw_cfg_t                  cfg,
    input  logic signed [jfw_pkg::DRIVE_W-1:0] drive,
    output jfw_pkg::jfw_wheel_pair_t           wheels
);

    logic [22:0]               prod_reg;
    logic [22:0]               prod_next;
    logic                      neg_c_reg;
    logic                      neg_c_next;
    logic [15:0]               quot_reg;
    logic [15:0]               quot_next;
    logic                      neg_d_reg;
    jfw_pkg::jfw_wheel_pair_t  wheels_reg;
    jfw_pkg::jfw_wheel_pair_t  wheels_next;

    logic signed [15:0] biased;
    logic [15:0]        biased_flip;
    logic [13:0]        bmag;
    logic [46:0]        recip_prod;
    logic signed [17:0] quot_s;
    logic signed [17:0] lim_s;
    logic signed [17:0] band_s;
    logic signed [17:0] v_raw;
    logic signed [17:0] v_band;
    logic signed [17:0] v_clamp;
    logic [17:0]        v_flip;
    logic               v_neg;
    logic [8:0]         v_mag;
    logic [jfw_pkg::PERIOD_W-1:0] period_minus;

    // |d + 127| * lim
    always_comb
    begin
        biased      = $signed({drive[jfw_pkg::DRIVE_W-1], drive})
                      + $signed(16'(jfw_pkg::AXIS_OUT_SPAN));
        biased_flip = 16'(-biased);
        neg_c_next  = biased[15];
        bmag        = biased[15] ? biased_flip[13:0] : biased[13:0];
        prod_next   = 23'(bmag) * 23'(cfg.speed_limit);
    end

    // divide by 127
    always_comb
    begin
        recip_prod = 47'(prod_reg) * 47'(jfw_pkg::DIV127_RECIP);
        quot_next  = recip_prod[jfw_pkg::DIV127_SHIFT +: 16];
    end

    // sign, offset, dead band, clamp, compare values
    always_comb
    begin
        quot_s = $signed({2'b0, quot_reg});
        lim_s  = $signed({9'b0, cfg.speed_limit});
        band_s = $signed({10'b0, cfg.dead_band});
        v_raw  = neg_d_reg ? (-quot_s - lim_s) : (quot_s - lim_s);

        v_band = v_raw;
        if (v_raw < band_s && v_raw > -band_s)
        begin
            v_band = '0;
        end

        priority if (v_band > lim_s)
        begin
            v_clamp = lim_s;
        end
        else if (v_band < -lim_s)
        begin
            v_clamp = -lim_s;
        end
        else
        begin
            v_clamp = v_band;
        end

        v_neg        = v_clamp[17];
        v_flip       = 18'(-v_clamp);
        v_mag        = v_neg ? v_flip[8:0] : v_clamp[8:0];
        period_minus = cfg.pwm_period - {1'b0, v_mag};

        wheels_next.direct_cmp = v_neg ? period_minus : {1'b0, v_mag};
        wheels_next.direct_dir = !v_neg;
        wheels_next.inv_cmp    = v_neg ? {1'b0, v_mag} : period_minus;
        wheels_next.inv_dir    = v_neg;
    end

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            prod_reg  <= prod_next;
            neg_c_reg <= neg_c_next;
        end
        if (en.mid)
        begin
            quot_reg  <= quot_next;
            neg_d_reg <= neg_c_reg;
        end
        if (en.last)
        begin
            wheels_reg <= wheels_next;
        end
    end

    assign wheels = wheels_reg;

endmodule

// ===== rtl/core/joystick_four_wheel_pwm_mixer.sv =====
// throughput: one item per cycle while the output is not stalled, six register
//   stages (input, two axis stages, drive product, reciprocal divide, output)
// a stalled output holds its item; the stages behind it keep filling bubbles
// reset: stage valid bits cleared, speed_limit 499, dead_band 20, pwm_period 500
module joystick_four_wheel_pwm_mixer (
    input  logic                                clk,
    input  logic                                rst_n,
    jfw_in_if.sink                              in_ch,
    jfw_out_if.source                           out_ch,
    input  logic                                cfg_wr_en,
    input  logic [jfw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [jfw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NS = jfw_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] load;

    logic [jfw_pkg::LIMIT_W-1:0]  speed_limit_reg;
    logic [jfw_pkg::BAND_W-1:0]   dead_band_reg;
    logic [jfw_pkg::PERIOD_W-1:0] pwm_period_reg;

    jfw_pkg::jfw_cfg_t        cfg;
    jfw_pkg::jfw_stage_en_t   axis_en;
    jfw_pkg::jfw_stage_en_t   drive_en;
    jfw_pkg::jfw_wheel_pair_t sum_wheels;
    jfw_pkg::jfw_wheel_pair_t diff_wheels;

    logic signed [jfw_pkg::AXIS_W-1:0]  x_axis;
    logic signed [jfw_pkg::AXIS_W-1:0]  y_axis;
    logic signed [jfw_pkg::DRIVE_W-1:0] sum_drive;
    logic signed [jfw_pkg::DRIVE_W-1:0] diff_drive;

    // a stage takes a new item when empty or when its item moves on
    always_comb
    begin
        load[NS-1] = !valid_reg[NS-1] || out_ch.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next = ({valid_reg[NS-2:0], in_ch.valid} & load) | (valid_reg & ~load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= jfw_pkg::SPEED_LIMIT_RESET;
            dead_band_reg   <= jfw_pkg::DEAD_BAND_RESET;
            pwm_period_reg  <= jfw_pkg::PWM_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                jfw_pkg::CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data[jfw_pkg::LIMIT_W-1:0];
                jfw_pkg::CFG_DEAD_BAND:   dead_band_reg   <= cfg_data[jfw_pkg::BAND_W-1:0];
                jfw_pkg::CFG_PWM_PERIOD:  pwm_period_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.speed_limit = speed_limit_reg;
    assign cfg.dead_band   = dead_band_reg;
    assign cfg.pwm_period  = pwm_period_reg;

    assign axis_en.first  = load[0];
    assign axis_en.mid    = load[1];
    assign axis_en.last   = load[2];
    assign drive_en.first = load[3];
    assign drive_en.mid   = load[4];
    assign drive_en.last  = load[5];

    jfw_axis u_x_axis (
        .clk       (clk),
        .en        (axis_en),
        .tens_char (in_ch.x_tens_char),
        .ones_char (in_ch.x_ones_char),
        .axis      (x_axis)
    );

    jfw_axis u_y_axis (
        .clk       (clk),
        .en        (axis_en),
        .tens_char (in_ch.y_tens_char),
        .ones_char (in_ch.y_ones_char),
        .axis      (y_axis)
    );

    assign sum_drive  = $signed({y_axis[jfw_pkg::AXIS_W-1], y_axis})
                        + $signed({x_axis[jfw_pkg::AXIS_W-1], x_axis});
    assign diff_drive = $signed({y_axis[jfw_pkg::AXIS_W-1], y_axis})
                        - $signed({x_axis[jfw_pkg::AXIS_W-1], x_axis});

    jfw_drive u_sum_drive (
        .clk    (clk),
        .en     (drive_en),
        .cfg    (cfg),
        .drive  (sum_drive),
        .wheels (sum_wheels)
    );

    jfw_drive u_diff_drive (
        .clk    (clk),
        .en     (drive_en),
        .cfg    (cfg),
        .drive  (diff_drive),
        .wheels (diff_wheels)
    );

    assign in_ch.ready = load[0];

    assign out_ch.valid               = valid_reg[NS-1];
    assign out_ch.front_left_compare  = sum_wheels.direct_cmp;
    assign out_ch.front_left_dir      = sum_wheels.direct_dir;
    assign out_ch.rear_right_compare  = sum_wheels.inv_cmp;
    assign out_ch.rear_right_dir      = sum_wheels.inv_dir;
    assign out_ch.front_right_compare = diff_wheels.inv_cmp;
    assign out_ch.front_right_dir     = diff_wheels.inv_dir;
    assign out_ch.rear_left_compare   = diff_wheels.direct_cmp;
    assign out_ch.rear_left_dir       = diff_wheels.direct_dir;

endmodule

// ===== rtl/core/jfw_checker.sv =====
`include "assert_macros.svh"

module jfw_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [jfw_pkg::PERIOD_W-1:0] front_left_compare,
    input logic                         front_left_dir,
    input logic [jfw_pkg::PERIOD_W-1:0] front_right_compare,
    input logic                         front_right_dir,
    input logic [jfw_pkg::PERIOD_W-1:0] rear_right_compare,
    input logic                         rear_right_dir,
    input logic [jfw_pkg::PERIOD_W-1:0] rear_left_compare,
    input logic                         rear_left_dir
);

    logic [4*jfw_pkg::PERIOD_W+3:0] out_fields;
    logic                           dirs_opposed;
    logic                           forward_in_range;

    assign out_fields = {front_left_compare, front_left_dir,
                         front_right_compare, front_right_dir,
                         rear_right_compare, rear_right_dir,
                         rear_left_compare, rear_left_dir};

    assign dirs_opposed = (front_left_dir != rear_right_dir)
                          && (rear_left_dir != front_right_dir);

    assign forward_in_range = !front_left_compare[jfw_pkg::PERIOD_W-1]
                              && (!rear_left_dir || !rear_left_compare[jfw_pkg::PERIOD_W-1]);

    // a stalled result stays put
    `JFW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

    // nothing waiting at the output means the pipe can take an item
    `JFW_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready)

    // wheels on the same drive point opposite ways on their direction pins
    `JFW_ASSERT_IMPL(a_dir_pairs, out_valid, dirs_opposed)

    // while front left drives forward, a forward direct compare is the drive itself, never above the limit range
    `JFW_ASSERT_IMPL(a_direct_range, out_valid && front_left_dir, forward_in_range)

endmodule

bind joystick_four_wheel_pwm_mixer jfw_checker u_jfw_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ready            (in_ch.ready),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .front_left_compare  (out_ch.front_left_compare),
    .front_left_dir      (out_ch.front_left_dir),
    .front_right_compare (out_ch.front_right_compare),
    .front_right_dir     (out_ch.front_right_dir),
    .rear_right_compare  (out_ch.rear_right_compare),
    .rear_right_dir      (out_ch.rear_right_dir),
    .rear_left_compare   (out_ch.rear_left_compare),
    .rear_left_dir       (out_ch.rear_left_dir)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int AXIS_HIGH      = 90;
    localparam int ITEMS_PER_SET  = 110;
    localparam int NUM_SETS       = 10;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [jfw_pkg::CHAR_W-1:0] x_tens;
        logic [jfw_pkg::CHAR_W-1:0] x_ones;
        logic [jfw_pkg::CHAR_W-1:0] y_tens;
        logic [jfw_pkg::CHAR_W-1:0] y_ones;
    } joystick_msg_t;

    typedef struct packed {
        logic [jfw_pkg::PERIOD_W-1:0] front_left_compare;
        logic                         front_left_dir;
        logic [jfw_pkg::PERIOD_W-1:0] front_right_compare;
        logic                         front_right_dir;
        logic [jfw_pkg::PERIOD_W-1:0] rear_right_compare;
        logic                         rear_right_dir;
        logic [jfw_pkg::PERIOD_W-1:0] rear_left_compare;
        logic                         rear_left_dir;
    } wheel_cmd_t;

    typedef enum int {ALWAYS_READY, COIN_FLIP, PERIODIC_STALL, RARE_STALL} ready_pattern_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [jfw_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [jfw_pkg::CFG_DATA_W-1:0] cfg_data;

    jfw_in_if  in_ch ();
    jfw_out_if out_ch ();

    joystick_four_wheel_pwm_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [jfw_pkg::LIMIT_W-1:0]  cur_limit;
    logic [jfw_pkg::BAND_W-1:0]   cur_band;
    logic [jfw_pkg::PERIOD_W-1:0] cur_period;

    joystick_msg_t  pending_msgs[$];
    wheel_cmd_t     expected_wheels[$];
    wheel_cmd_t     want;
    joystick_msg_t  next_msg;
    logic           in_taken;
    bit             failed;
    int             cycles;
    int             burst_left;
    int             gap_left;
    int             ready_left;
    int             stall_tick;
    ready_pattern_t ready_mode;

    function automatic longint axis_level(logic [jfw_pkg::CHAR_W-1:0] tens,
                                          logic [jfw_pkg::CHAR_W-1:0] ones);
        longint t;
        longint o;
        longint a;
        t = tens;
        o = ones;
        a = (t - jfw_pkg::DIGIT_BASE) * 10 + (o - jfw_pkg::DIGIT_BASE);
        return (a - jfw_pkg::AXIS_IN_LOW) * (2 * jfw_pkg::AXIS_OUT_SPAN)
               / (AXIS_HIGH - jfw_pkg::AXIS_IN_LOW) - jfw_pkg::AXIS_OUT_SPAN;
    endfunction

    function automatic longint shape_drive(longint d);
        longint lim;
        longint band;
        longint v;
        lim = cur_limit;
        band = cur_band;
        v = (d + jfw_pkg::AXIS_OUT_SPAN) * (2 * lim) / (2 * jfw_pkg::AXIS_OUT_SPAN) - lim;
        if (v < band && v > -band)
            v = 0;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic logic [jfw_pkg::PERIOD_W-1:0] direct_compare(longint v);
        longint p;
        longint c;
        p = cur_period;
        c = (v >= 0) ? v : p + v;
        return c[jfw_pkg::PERIOD_W-1:0];
    endfunction

    function automatic logic [jfw_pkg::PERIOD_W-1:0] inverted_compare(longint v);
        longint p;
        longint c;
        p = cur_period;
        c = (v >= 0) ? p - v : -v;
        return c[jfw_pkg::PERIOD_W-1:0];
    endfunction

    function automatic wheel_cmd_t predict_wheels(joystick_msg_t m);
        longint x;
        longint y;
        longint sum;
        longint diff;
        wheel_cmd_t r;
        x = axis_level(m.x_tens, m.x_ones);
        y = axis_level(m.y_tens, m.y_ones);
        sum = shape_drive(y + x);
        diff = shape_drive(y - x);
        r.front_left_compare  = direct_compare(sum);
        r.front_left_dir      = (sum >= 0);
        r.front_right_compare = inverted_compare(diff);
        r.front_right_dir     = (diff < 0);
        r.rear_right_compare  = inverted_compare(sum);
        r.rear_right_dir      = (sum < 0);
        r.rear_left_compare   = direct_compare(diff);
        r.rear_left_dir       = (diff >= 0);
        return r;
    endfunction

    task automatic compare_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s expected %0d actual %0d", field, exp_val, act_val);
            failed = 1;
        end
    endtask

    task automatic write_reg(input logic [jfw_pkg::CFG_INDEX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = jfw_pkg::CFG_DATA_W'(value);
        case (idx)
            jfw_pkg::CFG_SPEED_LIMIT: cur_limit  = jfw_pkg::LIMIT_W'(value);
            jfw_pkg::CFG_DEAD_BAND:   cur_band   = jfw_pkg::BAND_W'(value);
            jfw_pkg::CFG_PWM_PERIOD:  cur_period = jfw_pkg::PERIOD_W'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input int limit, input int band, input int period);
        write_reg(jfw_pkg::CFG_SPEED_LIMIT, limit);
        write_reg(jfw_pkg::CFG_DEAD_BAND, band);
        write_reg(jfw_pkg::CFG_PWM_PERIOD, period);
    endtask

    task automatic push_msg(input int xt, input int xo, input int yt, input int yo);
        joystick_msg_t m;
        m.x_tens = jfw_pkg::CHAR_W'(xt);
        m.x_ones = jfw_pkg::CHAR_W'(xo);
        m.y_tens = jfw_pkg::CHAR_W'(yt);
        m.y_ones = jfw_pkg::CHAR_W'(yo);
        pending_msgs.push_back(m);
    endtask

    task automatic push_axes(input int xv, input int yv);
        push_msg(jfw_pkg::DIGIT_BASE + xv / 10, jfw_pkg::DIGIT_BASE + xv % 10,
                 jfw_pkg::DIGIT_BASE + yv / 10, jfw_pkg::DIGIT_BASE + yv % 10);
    endtask

    task automatic push_directed();
        push_axes(10, 10);
        push_axes(90, 90);
        push_axes(10, 90);
        push_axes(90, 10);
        push_axes(50, 50);
        push_axes(47, 53);
        push_axes(0, 99);
        push_axes(99, 0);
        push_msg(0, 0, 0, 0);
        push_msg(255, 255, 255, 255);
        push_msg(255, 0, 0, 255);
        push_msg(0, 255, 255, 0);
    endtask

    task automatic push_random_msg();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
            push_axes($urandom_range(10, 90), $urandom_range(10, 90));
        else if (kind < 9)
            push_axes($urandom_range(0, 99), $urandom_range(0, 99));
        else
            push_msg($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic wait_idle();
        while (pending_msgs.size() != 0 || in_ch.valid || expected_wheels.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.x_tens_char = '0;
        in_ch.x_ones_char = '0;
        in_ch.y_tens_char = '0;
        in_ch.y_ones_char = '0;
        out_ch.ready = 1'b0;
        cur_limit = jfw_pkg::SPEED_LIMIT_RESET;
        cur_band = jfw_pkg::DEAD_BAND_RESET;
        cur_period = jfw_pkg::PWM_PERIOD_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int set = 0; set < NUM_SETS; set++)
        begin
            case (set)
                0: ;
                1: set_config(500, 0, 1023);
                2: set_config(0, 255, 1);
                3: set_config(500, 255, 1);
                4: set_config(500, 0, 1);
                default: set_config($urandom_range(0, 500), $urandom_range(0, 255),
                                    $urandom_range(1, 1023));
            endcase
            if (set == 0 || set == 3)
                push_directed();
            for (int i = 0; i < ITEMS_PER_SET; i++)
                push_random_msg();
            wait_idle();
        end

        repeat (jfw_pkg::NUM_STAGES + 10) @(posedge clk);
        if (expected_wheels.size() != 0)
        begin
            $error("%0d results never arrived", expected_wheels.size());
            failed = 1;
        end
        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // sender: bursts of items with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_msgs.size() > 0)
            begin
                next_msg = pending_msgs.pop_front();
                in_ch.x_tens_char <= next_msg.x_tens;
                in_ch.x_ones_char <= next_msg.x_ones;
                in_ch.y_tens_char <= next_msg.y_tens;
                in_ch.y_ones_char <= next_msg.y_ones;
                in_ch.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                             : $urandom_range(1, 12);
                    gap_left = $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver: stall pattern switches every so often
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_pattern_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        stall_tick++;
        case (ready_mode)
            ALWAYS_READY:   out_ch.ready <= 1'b1;
            COIN_FLIP:      out_ch.ready <= 1'($urandom_range(0, 1));
            PERIODIC_STALL: out_ch.ready <= (stall_tick % 7) >= 3;
            default:        out_ch.ready <= $urandom_range(0, 9) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            next_msg.x_tens = in_ch.x_tens_char;
            next_msg.x_ones = in_ch.x_ones_char;
            next_msg.y_tens = in_ch.y_tens_char;
            next_msg.y_ones = in_ch.y_ones_char;
            expected_wheels.push_back(predict_wheels(next_msg));
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_wheels.size() == 0)
            begin
                $error("output item with no expected result");
                failed = 1;
            end
            else
            begin
                want = expected_wheels.pop_front();
                compare_field("front_left_compare", want.front_left_compare,
                              out_ch.front_left_compare);
                compare_field("front_left_dir", want.front_left_dir, out_ch.front_left_dir);
                compare_field("front_right_compare", want.front_right_compare,
                              out_ch.front_right_compare);
                compare_field("front_right_dir", want.front_right_dir, out_ch.front_right_dir);
                compare_field("rear_right_compare", want.rear_right_compare,
                              out_ch.rear_right_compare);
                compare_field("rear_right_dir", want.rear_right_dir, out_ch.rear_right_dir);
                compare_field("rear_left_compare", want.rear_left_compare,
                              out_ch.rear_left_compare);
                compare_field("rear_left_dir", want.rear_left_dir, out_ch.rear_left_dir);
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/jfw_pkg.sv
rtl/core/jfw_channels.sv
rtl/core/jfw_axis.sv
rtl/core/jfw_drive.sv
rtl/core/joystick_four_wheel_pwm_mixer.sv
rtl/core/jfw_checker.sv
dv/tb.sv
